FILE: hw/rtl/hthermo_pkg.sv
// hthermo_pkg: shared types, codes and constants of the hysteresis thermostat
// depends on nothing; every other file imports it
package hthermo_pkg;

	// apb port geometry: 32-bit data bus, two 8-bit registers at byte addresses 0 and 4
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam int unsigned REG_W   = 8;
	localparam int unsigned REG_SEL_BIT = 2;

	// register indexes
	localparam logic REG_TICKS_PER_SAMPLE   = 1'b0;
	localparam logic REG_STEP_HOLDOFF_TICKS = 1'b1;

	localparam logic [REG_W-1:0] TICKS_PER_SAMPLE_RST   = 8'd50;
	localparam logic [REG_W-1:0] STEP_HOLDOFF_TICKS_RST = 8'd50;

	// item codes
	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_BUTTON = 1'b1;

	// button bit positions
	localparam int unsigned BTN_ENABLE  = 0;
	localparam int unsigned BTN_DISABLE = 1;
	localparam int unsigned BTN_UP      = 2;
	localparam int unsigned BTN_DOWN    = 3;

	// field widths
	localparam int unsigned CODE_W = 10;
	localparam int unsigned HYST_W = 7;
	localparam int unsigned BTN_W  = 4;

	localparam logic [HYST_W-1:0] HYST_MIN = 7'd1;
	localparam logic [HYST_W-1:0] HYST_MAX = 7'd99;
	localparam logic [HYST_W-1:0] HYST_RST = 7'd1;
	localparam logic [REG_W-1:0]  TICK_CNT_RST = 8'd50;

	// comparison scaled by 10*401*1023; all terms rearranged to be nonnegative
	//   on : 511500*t + 410223*h < 215443800 + 120300*p
	//   off: 511500*t > 215443800 + 120300*p + 410223*h
	localparam int unsigned CMP_W = 31;
	localparam logic [CMP_W-1:0] TEMP_GAIN = 31'd511500;
	localparam logic [CMP_W-1:0] SETP_GAIN = 31'd120300;
	localparam logic [CMP_W-1:0] HYST_GAIN = 31'd410223;
	localparam logic [CMP_W-1:0] SETP_OFFS = 31'd215443800;

	typedef struct packed {
		logic [REG_W-1:0] ticks_per_sample;
		logic [REG_W-1:0] step_holdoff_ticks;
	} cfg_t;

	typedef struct packed {
		logic turn_on;
		logic turn_off;
	} cmp_t;

endpackage

FILE: hw/rtl/hthermo_if.sv
// hthermo_if: valid/ready channels for input items and result beats
// depends on hthermo_pkg for field widths
interface hthermo_item_if;
	import hthermo_pkg::*;
	logic              valid;
	logic              ready;
	logic              action;
	logic [BTN_W-1:0]  buttons;
	logic [CODE_W-1:0] temp_code;
	logic [CODE_W-1:0] setpoint_code;

	modport source (output valid, action, buttons, temp_code, setpoint_code, input ready);
	modport sink (input valid, action, buttons, temp_code, setpoint_code, output ready);
endinterface

interface hthermo_result_if;
	import hthermo_pkg::*;
	logic              valid;
	logic              ready;
	logic              heater_drive;
	logic              enabled;
	logic [HYST_W-1:0] hysteresis_tenths;
	logic              updated;

	modport source (output valid, heater_drive, enabled, hysteresis_tenths, updated, input ready);
	modport sink (input valid, heater_drive, enabled, hysteresis_tenths, updated, output ready);
endinterface

FILE: hw/rtl/hthermo_cfg.sv
// hthermo_cfg: apb register file for sample period and step hold-off
// depends on hthermo_pkg
module hthermo_cfg
	import hthermo_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [REG_W-1:0] ticks_q;
	logic [REG_W-1:0] holdoff_q;
	logic             wr_en;
	logic             reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[REG_SEL_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q   <= TICKS_PER_SAMPLE_RST;
			holdoff_q <= STEP_HOLDOFF_TICKS_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_TICKS_PER_SAMPLE:   ticks_q   <= pwdata[REG_W-1:0];
				REG_STEP_HOLDOFF_TICKS: holdoff_q <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_TICKS_PER_SAMPLE:   prdata = PDATA_W'(ticks_q);
			REG_STEP_HOLDOFF_TICKS: prdata = PDATA_W'(holdoff_q);
			default:                prdata = '0;
		endcase
	end

	assign cfg.ticks_per_sample   = ticks_q;
	assign cfg.step_holdoff_ticks = holdoff_q;

endmodule

FILE: hw/rtl/hthermo_cmp.sv
// hthermo_cmp: exact scaled-integer compare of temperature against setpoint band
// depends on hthermo_pkg
module hthermo_cmp
	import hthermo_pkg::*;
(
	input  logic [CODE_W-1:0] temp_code,
	input  logic [CODE_W-1:0] setpoint_code,
	input  logic [HYST_W-1:0] hyst,
	output cmp_t              cmp
);

	logic [CMP_W-1:0] temp_term;
	logic [CMP_W-1:0] setp_term;
	logic [CMP_W-1:0] hyst_term;

	assign temp_term = CMP_W'(temp_code) * TEMP_GAIN;
	assign setp_term = SETP_OFFS + CMP_W'(setpoint_code) * SETP_GAIN;
	assign hyst_term = CMP_W'(hyst) * HYST_GAIN;

	// below the lower edge of the band / above the upper edge
	assign cmp.turn_on  = (temp_term + hyst_term) < setp_term;
	assign cmp.turn_off = temp_term > (setp_term + hyst_term);

endmodule

FILE: hw/rtl/hthermo_core.sv
// hthermo_core: input register, control state and result register
// depends on hthermo_pkg, hthermo_if and hthermo_cmp
module hthermo_core
	import hthermo_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	hthermo_item_if.sink             item,
	hthermo_result_if.source         result
);

	// input stage
	logic              valid_s1;
	logic              action_s1;
	logic [BTN_W-1:0]  buttons_s1;
	logic [CODE_W-1:0] temp_s1;
	logic [CODE_W-1:0] setp_s1;

	// control state
	logic [REG_W-1:0]  tick_cnt_q;
	logic [REG_W-1:0]  holdoff_q;
	logic              enable_q;
	logic              heater_q;
	logic [HYST_W-1:0] hyst_q;

	// result register
	logic              res_valid_q;
	logic              res_heater_q;
	logic              res_enabled_q;
	logic [HYST_W-1:0] res_hyst_q;
	logic              res_updated_q;

	logic              advance;
	logic              fire_s1;
	cmp_t              cmp;

	logic [REG_W-1:0]  tick_cnt_d;
	logic [REG_W-1:0]  tick_dec;
	logic [REG_W-1:0]  holdoff_d;
	logic              enable_d;
	logic              heater_d;
	logic [HYST_W-1:0] hyst_d;
	logic              updated_d;

	assign advance    = ~res_valid_q | result.ready;
	assign fire_s1    = valid_s1 & advance;
	assign item.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready & item.valid) begin
			action_s1  <= item.action;
			buttons_s1 <= item.buttons;
			temp_s1    <= item.temp_code;
			setp_s1    <= item.setpoint_code;
		end
	end

	hthermo_cmp u_cmp (
		.temp_code     (temp_s1),
		.setpoint_code (setp_s1),
		.hyst          (hyst_q),
		.cmp           (cmp)
	);

	assign tick_dec = tick_cnt_q - 1'b1;

	always_comb begin
		tick_cnt_d = tick_cnt_q;
		holdoff_d  = holdoff_q;
		enable_d   = enable_q;
		heater_d   = heater_q;
		hyst_d     = hyst_q;
		updated_d  = 1'b0;
		case (action_s1)
			ACT_TICK: begin
				if (holdoff_q != '0) begin
					holdoff_d = holdoff_q - 1'b1;
				end
				tick_cnt_d = tick_dec;
				if (tick_dec == '0) begin
					tick_cnt_d = cfg.ticks_per_sample;
					updated_d  = 1'b1;
					if (!enable_q) begin
						heater_d = 1'b0;
					end else if (cmp.turn_on) begin
						heater_d = 1'b1;
					end else if (cmp.turn_off) begin
						heater_d = 1'b0;
					end
				end
			end
			ACT_BUTTON: begin
				if (holdoff_q == '0) begin
					if (buttons_s1[BTN_ENABLE]) begin
						enable_d = 1'b1;
					end else if (buttons_s1[BTN_DISABLE]) begin
						enable_d = 1'b0;
					end else if (buttons_s1[BTN_UP] && hyst_q < HYST_MAX) begin
						hyst_d    = hyst_q + 1'b1;
						holdoff_d = cfg.step_holdoff_ticks;
					end else if (buttons_s1[BTN_DOWN] && hyst_q > HYST_MIN) begin
						hyst_d    = hyst_q - 1'b1;
						holdoff_d = cfg.step_holdoff_ticks;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q <= TICK_CNT_RST;
			holdoff_q  <= '0;
			enable_q   <= 1'b0;
			heater_q   <= 1'b0;
			hyst_q     <= HYST_RST;
		end else if (fire_s1) begin
			tick_cnt_q <= tick_cnt_d;
			holdoff_q  <= holdoff_d;
			enable_q   <= enable_d;
			heater_q   <= heater_d;
			hyst_q     <= hyst_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_heater_q  <= heater_d;
			res_enabled_q <= enable_d;
			res_hyst_q    <= hyst_d;
			res_updated_q <= updated_d;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.heater_drive      = res_heater_q;
	assign result.enabled           = res_enabled_q;
	assign result.hysteresis_tenths = res_hyst_q;
	assign result.updated           = res_updated_q;

endmodule

FILE: hw/rtl/hysteresis_thermostat.sv
// hysteresis_thermostat: on/off heater control with a stepped hysteresis band
// an accepted beat goes to the input register, and its result then to the result register
// one item per cycle unless result.ready stalls; state update and band compare sit in one stage
// result register decouples the sides: an empty input register takes a beat while a result waits
// reset: arst_n clears pipeline valids and loads period 50, hold-off 50,
// countdown 50, hysteresis 1 tenth, control disabled, heater off
module hysteresis_thermostat
	import hthermo_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	hthermo_item_if.sink       item,
	hthermo_result_if.source   result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	// register values shared with the control stage
	cfg_t cfg;

	// apb registers: sample period at byte 0, step hold-off at byte 4
	hthermo_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register, tick/button state machine, band compare, result register
	hthermo_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

endmodule
